[hw/rtl/kuw_pkg.sv]
// Shared types and constants of the Kuwahara smoothing filter.
package kuw_pkg;

    localparam int PIX_W      = 8;
    localparam int WIN        = 7;
    localparam int LINES      = 6;
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int CFG_W      = 13;
    localparam int S1_W       = 12;
    localparam int S2_W       = 20;
    localparam int VAR_W      = 24;
    localparam int WORD_W     = LINES * PIX_W;
    // ceil(2^16 / 18): exact for the rounded mean over nine pixels
    localparam logic [11:0] RECIP18 = 12'd3641;

    localparam logic [10:0] WIDTH_MAX  = 11'd1024;
    localparam logic [12:0] HEIGHT_MAX = 13'd4096;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             start_of_frame;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] filtered_value;
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_col;
        logic             last_of_frame;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ACC,
        S_VAR1,
        S_VAR2,
        S_MEAN,
        S_OUT
    } t_state;

    // pixels per quadrant, (d+1)^2
    function automatic logic [4:0] quad_count(input logic [1:0] d);
        logic [4:0] n;
        unique case (d)
            2'd0:    n = 5'd1;
            2'd1:    n = 5'd4;
            2'd2:    n = 5'd9;
            default: n = 5'd16;
        endcase
        return n;
    endfunction

endpackage

[hw/rtl/kuwahara_smoothing_filter_unit.sv]
// Top level of the Kuwahara smoothing filter: line store, window and quadrant statistics.
//
// Kuwahara smoothing over one 8-bit image band that arrives as a raster stream. Six
// line buffers share one synchronous memory of 1024 words, each word holding one column
// of all six lines; an item reads its column in the cycle it is accepted and writes it
// back, with the new pixel in place, in the next cycle. A 7x7 register window holds the
// neighbourhood. For every interior centre the four (d+1)x(d+1) quadrants are scanned
// one pixel a cycle through a single squaring unit, their variances are compared as
// N*sum(x^2) - (sum x)^2 (a tie keeps the earlier quadrant) and the rounded mean of the
// winner is emitted. The input stalls from an accepted item until that item is done, so
// a new item is taken only after the last one; an item that completes a centre also waits
// in its last state while the output register is full and stalled. A finished result waits in the
// output register while the next item is accepted. Border pixels give no result. Write
// configuration only while the block is idle; start_of_frame restarts the position
// counters, which also wrap by themselves at the configured width and height.
module kuwahara_smoothing_filter_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  kuw_pkg::t_in_item    i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output kuw_pkg::t_out_item   o_out_item,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [kuw_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int P = kuw_pkg::PIX_W;

    kuw_pkg::t_state r_state, n_state;

    // configuration
    logic [1:0]  r_radius;
    logic [10:0] r_width;
    logic [12:0] r_height;

    // position
    logic [kuw_pkg::ROW_W-1:0] r_row;
    logic [kuw_pkg::COL_W-1:0] r_col;
    logic [2:0]                r_line;

    // item in flight
    logic [P-1:0]              r_pix;
    logic [kuw_pkg::COL_W-1:0] r_addr;
    logic [2:0]                r_lane;
    logic                      r_emit;
    logic [kuw_pkg::ROW_W-1:0] r_row_out;
    logic [kuw_pkg::COL_W-1:0] r_col_out;
    logic                      r_last;

    // line store and window
    logic [kuw_pkg::WORD_W-1:0] mem [kuw_pkg::MAX_WIDTH];
    logic [kuw_pkg::WORD_W-1:0] r_rd_word;
    logic [kuw_pkg::WORD_W-1:0] wr_word;
    logic [P-1:0] r_win [kuw_pkg::WIN][kuw_pkg::WIN];
    logic [P-1:0] new_col [kuw_pkg::LINES];

    // statistics
    logic [1:0]                r_q, r_a, r_b;
    logic [kuw_pkg::S1_W-1:0]  r_s1, r_best_s1;
    logic [kuw_pkg::S2_W-1:0]  r_s2;
    logic [kuw_pkg::VAR_W-1:0] r_p1, r_p2, r_best_var;
    logic [24:0]               r_mprod;

    // output register
    logic                r_out_valid;
    kuw_pkg::t_out_item  r_out;

    logic                      accept;
    logic                      sof;
    logic [kuw_pkg::ROW_W-1:0] cur_row;
    logic [kuw_pkg::COL_W-1:0] cur_col;
    logic [2:0]                cur_line;
    logic [10:0]               w_eff;
    logic [12:0]               h_eff;
    logic [2:0]                d2;
    logic [10:0]               col_inc;
    logic [12:0]               row_inc;
    logic                      emit_now;
    logic [2:0]                r0, c0, win_r, win_c;
    logic [P-1:0]              v;
    logic [2*P-1:0]            sq;
    logic [4:0]                n_pix;
    logic [kuw_pkg::VAR_W-1:0] var_q;
    logic                      acc_done;
    logic                      out_free;
    logic [12:0]               mean_x;
    logic [12:0]               rnd4, rnd16;
    logic [P-1:0]              mean;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != kuw_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // position of the arriving item and the limits in force
    always_comb begin
        sof      = i_in_item.start_of_frame;
        cur_row  = sof ? '0 : r_row;
        cur_col  = sof ? '0 : r_col;
        cur_line = sof ? '0 : r_line;
        if (r_width == 11'd0)
            w_eff = 11'd1;
        else if (r_width > kuw_pkg::WIDTH_MAX)
            w_eff = kuw_pkg::WIDTH_MAX;
        else
            w_eff = r_width;
        if (r_height == 13'd0)
            h_eff = 13'd1;
        else if (r_height > kuw_pkg::HEIGHT_MAX)
            h_eff = kuw_pkg::HEIGHT_MAX;
        else
            h_eff = r_height;
        d2       = {r_radius, 1'b0};
        col_inc  = {1'b0, cur_col} + 11'd1;
        row_inc  = {1'b0, cur_row} + 13'd1;
        emit_now = (cur_row >= {9'd0, d2}) && (cur_col >= {7'd0, d2})
                && ({1'b0, cur_row} < h_eff) && ({1'b0, cur_col} < w_eff);
    end

    // column read from the line store, lines rotated so that the oldest comes first
    always_comb begin
        logic [3:0] lsum;
        for (int i = 0; i < kuw_pkg::LINES; i++) begin
            lsum = {1'b0, r_lane} + 4'(i);
            if (lsum >= 4'(kuw_pkg::LINES))
                lsum = lsum - 4'(kuw_pkg::LINES);
            new_col[i] = r_rd_word[lsum[2:0]*P +: P];
        end
        for (int k = 0; k < kuw_pkg::LINES; k++) begin
            wr_word[k*P +: P] = (3'(k) == r_lane) ? r_pix : r_rd_word[k*P +: P];
        end
    end

    // quadrant scan: one window pixel a cycle
    always_comb begin
        r0       = ((r_q == 2'd0) || (r_q == 2'd2)) ? 3'd6 - d2 : 3'd6 - {1'b0, r_radius};
        c0       = (r_q < 2'd2) ? 3'd6 - d2 : 3'd6 - {1'b0, r_radius};
        win_r    = r0 + {1'b0, r_a};
        win_c    = c0 + {1'b0, r_b};
        v        = r_win[win_r][win_c];
        sq       = v * v;
        n_pix    = kuw_pkg::quad_count(r_radius);
        var_q    = r_p1 - r_p2;
        acc_done = (r_a == r_radius) && (r_b == r_radius);
        mean_x   = {r_best_s1, 1'b0} + 13'd9;
        rnd4     = ({1'b0, r_best_s1} + 13'd2) >> 2;
        rnd16    = ({1'b0, r_best_s1} + 13'd8) >> 4;
        case (r_radius)
            2'd0:    mean = r_best_s1[P-1:0];
            2'd1:    mean = rnd4[P-1:0];
            2'd2:    mean = r_mprod[23:16];
            default: mean = rnd16[P-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= kuw_pkg::S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kuw_pkg::S_IDLE: if (accept) n_state = kuw_pkg::S_LOAD;
            kuw_pkg::S_LOAD: n_state = r_emit ? kuw_pkg::S_ACC : kuw_pkg::S_IDLE;
            kuw_pkg::S_ACC:  if (acc_done) n_state = kuw_pkg::S_VAR1;
            kuw_pkg::S_VAR1: n_state = kuw_pkg::S_VAR2;
            kuw_pkg::S_VAR2: n_state = (r_q == 2'd3) ? kuw_pkg::S_MEAN : kuw_pkg::S_ACC;
            kuw_pkg::S_MEAN: n_state = kuw_pkg::S_OUT;
            kuw_pkg::S_OUT:  if (out_free) n_state = kuw_pkg::S_IDLE;
            default:         n_state = kuw_pkg::S_IDLE;
        endcase
    end

    // line store: read on accept, write back the modified column next cycle
    always_ff @(posedge i_clk) begin
        if (accept)
            r_rd_word <= mem[cur_col];
        if (r_state == kuw_pkg::S_LOAD)
            mem[r_addr] <= wr_word;
    end

    // control: configuration, position counters, window, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= 2'd1;
            r_width     <= 11'd640;
            r_height    <= 13'd480;
            r_row       <= '0;
            r_col       <= '0;
            r_line      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < kuw_pkg::WIN; i++)
                for (int j = 0; j < kuw_pkg::WIN; j++)
                    r_win[i][j] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kuw_pkg::CFG_RADIUS: r_radius <= i_cfg_data[1:0];
                    kuw_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                    kuw_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                // advance to the next position, wrapping at width and height
                if (col_inc >= w_eff) begin
                    r_col <= '0;
                    if (row_inc >= h_eff) begin
                        r_row  <= '0;
                        r_line <= '0;
                    end else begin
                        r_row  <= row_inc[kuw_pkg::ROW_W-1:0];
                        r_line <= (cur_line == 3'(kuw_pkg::LINES - 1)) ? 3'd0
                                                                       : cur_line + 3'd1;
                    end
                end else begin
                    r_col <= col_inc[kuw_pkg::COL_W-1:0];
                    r_row <= cur_row;
                    r_line <= cur_line;
                end
            end
            if (r_state == kuw_pkg::S_LOAD) begin
                // shift the window left and load the new column
                for (int i = 0; i < kuw_pkg::WIN; i++)
                    for (int j = 0; j < kuw_pkg::WIN - 1; j++)
                        r_win[i][j] <= r_win[i][j+1];
                for (int i = 0; i < kuw_pkg::LINES; i++)
                    r_win[i][kuw_pkg::WIN-1] <= new_col[i];
                r_win[kuw_pkg::WIN-1][kuw_pkg::WIN-1] <= r_pix;
            end
            if (r_state == kuw_pkg::S_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    // datapath: item fields, quadrant statistics, result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix     <= i_in_item.pixel_value;
            r_addr    <= cur_col;
            r_lane    <= cur_line;
            r_emit    <= emit_now;
            r_row_out <= cur_row - {10'd0, r_radius};
            r_col_out <= cur_col - {8'd0, r_radius};
            r_last    <= (row_inc == h_eff) && (col_inc == w_eff);
        end
        unique case (r_state)
            kuw_pkg::S_LOAD: begin
                r_q  <= 2'd0;
                r_a  <= 2'd0;
                r_b  <= 2'd0;
                r_s1 <= '0;
                r_s2 <= '0;
            end
            kuw_pkg::S_ACC: begin
                r_s1 <= r_s1 + kuw_pkg::S1_W'(v);
                r_s2 <= r_s2 + kuw_pkg::S2_W'(sq);
                if (r_b == r_radius) begin
                    r_b <= 2'd0;
                    r_a <= r_a + 2'd1;
                end else begin
                    r_b <= r_b + 2'd1;
                end
            end
            kuw_pkg::S_VAR1: begin
                r_p1 <= kuw_pkg::VAR_W'(n_pix) * kuw_pkg::VAR_W'(r_s2);
                r_p2 <= r_s1 * r_s1;
            end
            kuw_pkg::S_VAR2: begin
                if (r_q == 2'd0 || var_q < r_best_var) begin
                    r_best_var <= var_q;
                    r_best_s1  <= r_s1;
                end
                r_q  <= r_q + 2'd1;
                r_a  <= 2'd0;
                r_b  <= 2'd0;
                r_s1 <= '0;
                r_s2 <= '0;
            end
            kuw_pkg::S_MEAN: begin
                r_mprod <= mean_x * kuw_pkg::RECIP18;
            end
            kuw_pkg::S_OUT: begin
                if (out_free) begin
                    r_out.filtered_value <= mean;
                    r_out.centre_row     <= r_row_out;
                    r_out.centre_col     <= r_col_out;
                    r_out.last_of_frame  <= r_last;
                end
            end
            default: ;
        endcase
    end

endmodule

[hw/rtl/kuw_checker.sv]
// Port checker of the Kuwahara smoothing filter and its bind.
module kuw_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input kuw_pkg::t_out_item o_out_item
);

    // a stalled item holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled output item changed");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // one item at a time: an accepted item closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after an accepted item");

endmodule

bind kuwahara_smoothing_filter_unit kuw_port_checker u_kuw_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

[verif/kuw_checker.sv]
// Checker of the Kuwahara filter: watches both channels, predicts and compares results.
`timescale 1ns / 100ps

module kuw_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  kuw_pkg::t_in_item     i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  kuw_pkg::t_out_item    i_out_item,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [kuw_pkg::CFG_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results
);

    logic [kuw_pkg::PIX_W-1:0] win_px [kuw_pkg::WIN][kuw_pkg::WIN];
    logic [kuw_pkg::PIX_W-1:0] line_px [kuw_pkg::LINES][kuw_pkg::MAX_WIDTH];
    int unsigned               row_pos, col_pos;
    logic [1:0]                radius;
    logic [10:0]               width_cfg;
    logic [12:0]               height_cfg;
    kuw_pkg::t_out_item        smoothed_q[$];

    initial begin
        o_errors  = 0;
        o_results = 0;
        foreach (line_px[i, j]) line_px[i][j] = '0;
    end

    assign o_pending = smoothed_q.size();

    // Advance the filter image by one pixel; queue the smoothed pixel it completes.
    task automatic predict_pixel(input kuw_pkg::t_in_item it);
        int unsigned d, w, h, r, c, cc, n, r0, c0;
        longint unsigned s1, s2, v, var_q, best_var, best_s1;
        kuw_pkg::t_out_item res;
        best_var = 0;
        best_s1  = 0;
        d = radius;
        w = width_cfg;
        h = height_cfg;
        if (w < 1) w = 1;
        if (w > kuw_pkg::MAX_WIDTH) w = kuw_pkg::MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > 4096) h = 4096;
        if (it.start_of_frame) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos % kuw_pkg::MAX_WIDTH;
        for (int i = 0; i < kuw_pkg::WIN; i++)
            for (int j = 0; j < kuw_pkg::WIN - 1; j++)
                win_px[i][j] = win_px[i][j+1];
        for (int i = 0; i < kuw_pkg::WIN - 1; i++)
            win_px[i][kuw_pkg::WIN-1] = line_px[(r + i) % kuw_pkg::LINES][c];
        win_px[kuw_pkg::WIN-1][kuw_pkg::WIN-1] = it.pixel_value;
        line_px[r % kuw_pkg::LINES][c] = it.pixel_value;
        if (r >= 2*d && c >= 2*d && r < h && c < w) begin
            cc = kuw_pkg::WIN - 1 - d;
            n  = (d + 1) * (d + 1);
            for (int q = 0; q < 4; q++) begin
                r0 = (q == 0 || q == 2) ? cc - d : cc;
                c0 = (q < 2) ? cc - d : cc;
                s1 = 0;
                s2 = 0;
                for (int i = r0; i <= r0 + d; i++)
                    for (int j = c0; j <= c0 + d; j++) begin
                        v = win_px[i][j];
                        s1 += v;
                        s2 += v * v;
                    end
                var_q = n * s2 - s1 * s1;
                // a tie keeps the earlier quadrant
                if (q == 0 || var_q < best_var) begin
                    best_var = var_q;
                    best_s1  = s1;
                end
            end
            res.filtered_value = kuw_pkg::PIX_W'((2*best_s1 + n) / (2*n));
            res.centre_row     = kuw_pkg::ROW_W'(r - d);
            res.centre_col     = kuw_pkg::COL_W'(c - d);
            res.last_of_frame  = (r + 1 == h && c + 1 == w);
            smoothed_q.push_back(res);
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
    endtask

    always @(posedge i_clk) begin
        kuw_pkg::t_out_item exp_item;
        if (!i_rst_n) begin
            radius     = 2'd1;
            width_cfg  = 11'd640;
            height_cfg = 13'd480;
            row_pos    = 0;
            col_pos    = 0;
            foreach (win_px[i, j]) win_px[i][j] = '0;
            smoothed_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    kuw_pkg::CFG_RADIUS: radius     = i_cfg_data[1:0];
                    kuw_pkg::CFG_WIDTH:  width_cfg  = i_cfg_data[10:0];
                    kuw_pkg::CFG_HEIGHT: height_cfg = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_pixel(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (smoothed_q.size() == 0) begin
                    $error("unexpected result: row %0d col %0d",
                           i_out_item.centre_row, i_out_item.centre_col);
                    o_errors++;
                end else begin
                    exp_item = smoothed_q.pop_front();
                    if (i_out_item.filtered_value !== exp_item.filtered_value) begin
                        $error("filtered_value: expected %0d, actual %0d",
                               exp_item.filtered_value, i_out_item.filtered_value);
                        o_errors++;
                    end
                    if (i_out_item.centre_row !== exp_item.centre_row) begin
                        $error("centre_row: expected %0d, actual %0d",
                               exp_item.centre_row, i_out_item.centre_row);
                        o_errors++;
                    end
                    if (i_out_item.centre_col !== exp_item.centre_col) begin
                        $error("centre_col: expected %0d, actual %0d",
                               exp_item.centre_col, i_out_item.centre_col);
                        o_errors++;
                    end
                    if (i_out_item.last_of_frame !== exp_item.last_of_frame) begin
                        $error("last_of_frame: expected %0d, actual %0d",
                               exp_item.last_of_frame, i_out_item.last_of_frame);
                        o_errors++;
                    end
                end
            end
        end
    end

endmodule

[verif/tb_kuwahara_smoothing_filter_unit.sv]
// Testbench top of the Kuwahara filter: clock, reset, pixel stream, stalls and verdict.
`timescale 1ns / 100ps

module tb_kuwahara_smoothing_filter_unit;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    kuw_pkg::t_in_item         in_item = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    kuw_pkg::t_out_item        out_item;
    logic                      cfg_we = 1'b0;
    logic [1:0]                cfg_idx = kuw_pkg::CFG_RADIUS;
    logic [kuw_pkg::CFG_W-1:0] cfg_data = '0;

    int errors, pending, results;
    int idle_pct  = 7;     // sender gap chance, per cent
    int stall_pct = 7;     // receiver stall chance, per cent
    bit hold_req  = 1'b0;  // ask the receiver for one long hold-off
    bit hold_done = 1'b0;
    int hold_at   = 0;     // pixel count at which the hold-off starts
    int pixels_sent = 0;
    int phases = 0;

    kuwahara_smoothing_filter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    kuw_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Hard stop in case the block wedges.
    initial begin
        #2000000;
        $display("Timeout waiting for the filter to drain");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off mid-stream so the block backs up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done && pixels_sent >= hold_at) begin
                out_stall <= 1'b1;
                repeat (399) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Offer one item and hold it until accepted; valid stays high for a following item.
    task automatic send_pixel(input logic [7:0] pix, input logic sof);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{pixel_value: pix, start_of_frame: sof};
        do @(posedge i_clk); while (in_stall);
        pixels_sent++;
    endtask

    // Drop valid, let every expected result arrive, then allow the block to settle.
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_config(input int d, input int w, input int h);
        cfg_we   <= 1'b1;
        cfg_idx  <= kuw_pkg::CFG_RADIUS;
        cfg_data <= kuw_pkg::CFG_W'(d);
        @(posedge i_clk);
        cfg_idx  <= kuw_pkg::CFG_WIDTH;
        cfg_data <= kuw_pkg::CFG_W'(w);
        @(posedge i_clk);
        cfg_idx  <= kuw_pkg::CFG_HEIGHT;
        cfg_data <= kuw_pkg::CFG_W'(h);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] texture(input int mode, input int k);
        case (mode)
            0: return 8'($urandom_range(255));
            1: return $urandom_range(1) ? 8'd255 : 8'd0;
            2: return 8'(100 + $urandom_range(2));
            default: return 8'(k * 7 + $urandom_range(3));
        endcase
    endfunction

    // Stream whole frames of one configuration; a few frames rely on the counter wrap
    // instead of start_of_frame, and a rare stray start_of_frame breaks a frame.
    task automatic run_frames(input int d, input int w, input int h, input int frames);
        int we, he, mode;
        bit sof;
        we = (w < 1) ? 1 : (w > 1024 ? 1024 : w);
        he = (h < 1) ? 1 : (h > 4096 ? 4096 : h);
        drain();
        set_config(d, w, h);
        phases++;
        for (int f = 0; f < frames; f++) begin
            mode = $urandom_range(3);
            for (int k = 0; k < we * he; k++) begin
                if (k == 0)
                    sof = (f == 0) || ($urandom_range(19) != 0);
                else
                    sof = ($urandom_range(199) == 0);
                send_pixel(texture(mode, k), sof);
            end
        end
    endtask

    initial begin
        int rnd_start;
        logic [7:0] edge_px [9];
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extreme pixels at radius one, a flat tie, then single-pixel quadrants.
        edge_px = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
        drain();
        set_config(1, 3, 3);
        for (int k = 0; k < 9; k++) send_pixel(edge_px[k], k == 0);
        for (int k = 0; k < 9; k++) send_pixel(8'd37, k == 0);
        drain();
        set_config(0, 3, 3);
        for (int k = 0; k < 6; k++) send_pixel(8'(255 - k), k == 0);

        // Long hold-off in the third row of a wider frame, where pixels from the third column on emit.
        hold_at  = pixels_sent + 110;
        hold_req = 1'b1;
        run_frames(1, 48, 4, 1);
        run_frames(3, 12, 7, 1);
        idle_pct  = 0;
        stall_pct = 0;
        run_frames(1, 3, 40, 1);
        idle_pct  = 7;
        stall_pct = 7;
        run_frames(3, 7, 7, 2);
        run_frames(2, 0, 5, 2);
        run_frames(0, 4, 0, 3);

        // Random part: mostly small frames across all radii.
        rnd_start = pixels_sent;
        while (pixels_sent - rnd_start < 600)
            run_frames($urandom_range(3), $urandom_range(3, 12),
                       $urandom_range(3, 10), $urandom_range(1, 3));
        drain();

        $display("Sent %0d pixels over %0d configurations, checked %0d smoothed pixels",
                 pixels_sent, phases, results);
        $display("Covered radii 0..3, zero width and height, tall and wide frames, a long output hold");
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
hw/rtl/kuw_pkg.sv
hw/rtl/kuwahara_smoothing_filter_unit.sv
hw/rtl/kuw_checker.sv
verif/kuw_checker.sv
verif/tb_kuwahara_smoothing_filter_unit.sv
